// File: design/point_segment_projection_macros.svh
// Assertion macros for the point to segment projection block.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef POINT_SEGMENT_PROJECTION_MACROS_SVH
`define POINT_SEGMENT_PROJECTION_MACROS_SVH

`ifndef ASSERT_OFF
// Condition that must hold at every clock edge outside reset.
`define PSP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Implication checked at every clock edge outside reset.
`define PSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define PSP_ASSERT(lbl, cond, msg)
`define PSP_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// File: design/psp_pkg.sv
`timescale 1ns / 1ps
package psp_pkg;

  // Default coordinate width, signed Q16.16.
  localparam int COORD_WIDTH_DEFAULT = 32;
  // Tolerance register width and its alignment to the Q32.32 dot product.
  localparam int TOL_WIDTH = 31;
  localparam int TOL_SHIFT = 16;

endpackage

// File: design/psp_ifs.sv
`timescale 1ns / 1ps
interface psp_in_if #(
  parameter int W = psp_pkg::COORD_WIDTH_DEFAULT
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic signed [W-1:0] point_z;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] start_z;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;
  logic signed [W-1:0] end_z;

  modport source (
    output valid, point_x, point_y, point_z, start_x, start_y, start_z,
           end_x, end_y, end_z,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, start_x, start_y, start_z,
           end_x, end_y, end_z,
    output ready
  );
endinterface

interface psp_out_if #(
  parameter int W = psp_pkg::COORD_WIDTH_DEFAULT
);
  logic                valid;
  logic                ready;
  logic                on_segment;
  logic signed [W-1:0] proj_x;
  logic signed [W-1:0] proj_y;
  logic signed [W-1:0] proj_z;

  modport source (
    output valid, on_segment, proj_x, proj_y, proj_z,
    input  ready
  );
  modport sink (
    input  valid, on_segment, proj_x, proj_y, proj_z,
    output ready
  );
endinterface

// File: design/point_segment_projection.sv
`timescale 1ns / 1ps
// Projects a 3D point onto a line segment, all coordinates signed Q16.16.
// Each request carries the point and both segment ends; the result gives an
// on-segment flag and, when it is set, the projected point
// start + v * d / |v|^2 with the quotient truncated toward zero and each
// coordinate saturated to the coordinate range (zeros when off segment).
// The test passes when -eps <= d <= |v|^2 + eps, with eps the tolerance
// register shifted left by 16. A zero-length segment always passes and
// returns its start point. The block accepts one request per clock and
// returns one result per clock while the output is not stalled; the
// restoring divider, one quotient bit per stage, produces COORD_WIDTH + 2
// quotient bits. Every stage holds its own valid bit, so empty stages fill
// up while the output is stalled. The tolerance register should be written
// only while no request is in flight.
module point_segment_projection #(
  parameter int COORD_WIDTH = psp_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  psp_in_if.sink                        in_chan,
  psp_out_if.source                     out_chan,
  input  logic                          cfg_wr_en,
  input  logic [psp_pkg::TOL_WIDTH-1:0] cfg_wr_data
);
  localparam int W    = COORD_WIDTH;
  localparam int NW   = 3 * W + 3;
  localparam int LW   = 2 * W + 2;
  localparam int QW   = W + 2;
  localparam int SB_W = 3 * W + 8;
  localparam int RW   = W + 4;

  logic [psp_pkg::TOL_WIDTH-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  // Front end: differences, dot product, squared length and bounds test.
  logic signed [W-1:0] pt [3];
  logic signed [W-1:0] st [3];
  logic signed [W-1:0] ep [3];
  logic                f_vld, f_rdy, f_on, f_zl, f_neg;
  logic [LW-1:0]       f_mag, f_len;
  logic signed [W:0]   f_dir [3];
  logic signed [W-1:0] f_start [3];

  assign pt = '{in_chan.point_x, in_chan.point_y, in_chan.point_z};
  assign st = '{in_chan.start_x, in_chan.start_y, in_chan.start_z};
  assign ep = '{in_chan.end_x, in_chan.end_y, in_chan.end_z};

  psp_front #(.W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .tol      (tol_r),
    .up_vld   (in_chan.valid),
    .up_rdy   (in_chan.ready),
    .pt       (pt),
    .st       (st),
    .ep       (ep),
    .dn_vld   (f_vld),
    .dn_rdy   (f_rdy),
    .on_seg   (f_on),
    .zero_len (f_zl),
    .dot_neg  (f_neg),
    .dot_mag  (f_mag),
    .len      (f_len),
    .dir      (f_dir),
    .start    (f_start)
  );

  // Numerator per axis and the range check on the quotient.
  logic                s_vld, s_rdy, s_on, s_zl;
  logic [2:0]          s_neg, s_ovf;
  logic [NW-1:0]       s_num [3];
  logic [LW-1:0]       s_len;
  logic signed [W-1:0] s_start [3];

  psp_scale #(.W(W)) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_vld    (f_vld),
    .up_rdy    (f_rdy),
    .on_seg    (f_on),
    .zero_len  (f_zl),
    .dot_neg   (f_neg),
    .dot_mag   (f_mag),
    .len       (f_len),
    .dir       (f_dir),
    .start     (f_start),
    .dn_vld    (s_vld),
    .dn_rdy    (s_rdy),
    .on_out    (s_on),
    .zl_out    (s_zl),
    .neg_out   (s_neg),
    .ovf_out   (s_ovf),
    .num_out   (s_num),
    .len_out   (s_len),
    .start_out (s_start)
  );

  // Division by the squared length; the side word keeps the flags and the
  // start point aligned with the quotients.
  logic              d_vld, d_rdy;
  logic [SB_W-1:0]   d_sb_in, d_sb;
  logic [QW-1:0]     d_quo [3];

  assign d_sb_in = {s_on, s_zl, s_neg, s_ovf, s_start[2], s_start[1], s_start[0]};

  psp_divider #(.W(W), .SB_W(SB_W)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .up_vld (s_vld),
    .up_rdy (s_rdy),
    .num    (s_num),
    .len    (s_len),
    .sb_in  (d_sb_in),
    .dn_vld (d_vld),
    .dn_rdy (d_rdy),
    .quo    (d_quo),
    .sb_out (d_sb)
  );

  // Output stage: signed add onto the start point, saturation and zeroing.
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  logic                out_vld_r;
  logic                on_r;
  logic signed [W-1:0] proj_r [3];
  logic signed [W-1:0] proj_nxt [3];
  logic                o_on, o_zl;
  logic [2:0]          o_neg, o_ovf;
  logic signed [W-1:0] o_s [3];
  logic signed [RW-1:0] sum [3];

  assign o_on  = d_sb[3*W+7];
  assign o_zl  = d_sb[3*W+6];
  assign o_neg = d_sb[3*W+3 +: 3];
  assign o_ovf = d_sb[3*W +: 3];
  for (genvar i = 0; i < 3; i++) begin : g_unpk
    assign o_s[i] = d_sb[W*i +: W];
  end

  assign d_rdy = !out_vld_r || out_chan.ready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = o_neg[i] ? (RW'(o_s[i]) - RW'(d_quo[i])) : (RW'(o_s[i]) + RW'(d_quo[i]));
      if (!o_on) begin
        proj_nxt[i] = '0;
      end else if (o_zl) begin
        proj_nxt[i] = o_s[i];
      end else if (o_ovf[i]) begin
        proj_nxt[i] = o_neg[i] ? CMIN : CMAX;
      end else if (sum[i] > RW'(CMAX)) begin
        proj_nxt[i] = CMAX;
      end else if (sum[i] < RW'(CMIN)) begin
        proj_nxt[i] = CMIN;
      end else begin
        proj_nxt[i] = sum[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (d_rdy) begin
      out_vld_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (d_rdy) begin
      on_r   <= o_on;
      proj_r <= proj_nxt;
    end
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.on_segment = on_r;
  assign out_chan.proj_x     = proj_r[0];
  assign out_chan.proj_y     = proj_r[1];
  assign out_chan.proj_z     = proj_r[2];

`include "point_segment_projection_macros.svh"

  // An off-segment result always carries a zero point.
  `PSP_ASSERT_IMP(a_off_zero, out_chan.valid && !out_chan.on_segment, (out_chan.proj_x == '0) && (out_chan.proj_y == '0) && (out_chan.proj_z == '0), "off-segment result with nonzero point")
  // The input side only stalls when the whole pipe is full behind a held result.
  `PSP_ASSERT_IMP(a_stall_src, !in_chan.ready, out_chan.valid && !out_chan.ready, "input stalled without output backpressure")
  // Nothing leaves the block in the first cycle after reset.
  `PSP_ASSERT_IMP(a_reset_empty, $past(!rst_n), !out_chan.valid, "result presented right after reset")
endmodule

// File: design/psp_front.sv
`timescale 1ns / 1ps
// Differences, products, dot product and the bounds test, four stages.
module psp_front #(
  parameter int W = psp_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [psp_pkg::TOL_WIDTH-1:0]     tol,
  input  logic                              up_vld,
  output logic                              up_rdy,
  input  logic signed [W-1:0]               pt [3],
  input  logic signed [W-1:0]               st [3],
  input  logic signed [W-1:0]               ep [3],
  output logic                              dn_vld,
  input  logic                              dn_rdy,
  output logic                              on_seg,
  output logic                              zero_len,
  output logic                              dot_neg,
  output logic [2*W+1:0]                    dot_mag,
  output logic [2*W+1:0]                    len,
  output logic signed [W:0]                 dir [3],
  output logic signed [W-1:0]               start [3]
);
  localparam int DW   = 2 * W + 3;
  localparam int LW   = 2 * W + 2;
  localparam int TOLX = psp_pkg::TOL_WIDTH + psp_pkg::TOL_SHIFT;
  localparam int CW   = ((LW > TOLX) ? LW : TOLX) + 1;

  logic [3:0] vld_r;
  logic [4:0] adv;

  logic signed [W:0]      v1_r [3];
  logic signed [W:0]      w1_r [3];
  logic signed [W-1:0]    s1_r [3];
  logic signed [2*W+1:0]  pw2_r [3];
  logic signed [2*W+1:0]  pv2_r [3];
  logic signed [W:0]      v2_r [3];
  logic signed [W-1:0]    s2_r [3];
  logic signed [DW-1:0]   dot3_r;
  logic [LW-1:0]          len3_r;
  logic signed [W:0]      v3_r [3];
  logic signed [W-1:0]    s3_r [3];
  logic                   on4_r;
  logic                   zl4_r;
  logic                   neg4_r;
  logic [LW-1:0]          mag4_r;
  logic [LW-1:0]          len4_r;
  logic signed [W:0]      v4_r [3];
  logic signed [W-1:0]    s4_r [3];

  logic signed [DW-1:0]   dot3_nxt;
  logic [LW-1:0]          len3_nxt;
  logic                   dneg;
  logic signed [DW-1:0]   dabs;
  logic [LW-1:0]          dmag;
  logic [CW-1:0]          eps;
  logic                   viol_lo;
  logic                   viol_hi;

  // A stage takes new data when it is empty or its contents move on.
  assign adv[4] = dn_rdy;
  for (genvar k = 0; k < 4; k++) begin : g_adv
    assign adv[k] = !vld_r[k] || adv[k+1];
  end
  assign up_rdy = adv[0];
  assign dn_vld = vld_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= up_vld;
      for (int k = 1; k < 4; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_comb begin
    dot3_nxt = DW'(pw2_r[0]) + DW'(pw2_r[1]) + DW'(pw2_r[2]);
    len3_nxt = LW'(pv2_r[0][2*W:0]) + LW'(pv2_r[1][2*W:0]) + LW'(pv2_r[2][2*W:0]);
    dneg     = dot3_r[DW-1];
    dabs     = dneg ? -dot3_r : dot3_r;
    dmag     = dabs[LW-1:0];
    eps      = CW'({tol, {psp_pkg::TOL_SHIFT{1'b0}}});
    viol_lo  = dneg && (CW'(dmag) > eps);
    viol_hi  = !dneg && (CW'(dmag) > (CW'(len3_r) + eps));
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < 3; i++) begin
        v1_r[i] <= {ep[i][W-1], ep[i]} - {st[i][W-1], st[i]};
        w1_r[i] <= {pt[i][W-1], pt[i]} - {st[i][W-1], st[i]};
        s1_r[i] <= st[i];
      end
    end
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        pw2_r[i] <= w1_r[i] * v1_r[i];
        pv2_r[i] <= v1_r[i] * v1_r[i];
        v2_r[i]  <= v1_r[i];
        s2_r[i]  <= s1_r[i];
      end
    end
    if (adv[2]) begin
      dot3_r <= dot3_nxt;
      len3_r <= len3_nxt;
      v3_r   <= v2_r;
      s3_r   <= s2_r;
    end
    if (adv[3]) begin
      on4_r  <= !viol_lo && !viol_hi;
      zl4_r  <= (len3_r == '0);
      neg4_r <= dneg;
      mag4_r <= dmag;
      len4_r <= len3_r;
      v4_r   <= v3_r;
      s4_r   <= s3_r;
    end
  end

  assign on_seg   = on4_r;
  assign zero_len = zl4_r;
  assign dot_neg  = neg4_r;
  assign dot_mag  = mag4_r;
  assign len      = len4_r;
  assign dir      = v4_r;
  assign start    = s4_r;
endmodule

// File: design/psp_scale.sv
`timescale 1ns / 1ps
// Forms |v| * |d| per axis from split partial products and checks the
// quotient against its range, three stages.
module psp_scale #(
  parameter int W = psp_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_vld,
  output logic                  up_rdy,
  input  logic                  on_seg,
  input  logic                  zero_len,
  input  logic                  dot_neg,
  input  logic [2*W+1:0]        dot_mag,
  input  logic [2*W+1:0]        len,
  input  logic signed [W:0]     dir [3],
  input  logic signed [W-1:0]   start [3],
  output logic                  dn_vld,
  input  logic                  dn_rdy,
  output logic                  on_out,
  output logic                  zl_out,
  output logic [2:0]            neg_out,
  output logic [2:0]            ovf_out,
  output logic [3*W+2:0]        num_out [3],
  output logic [2*W+1:0]        len_out,
  output logic signed [W-1:0]   start_out [3]
);
  localparam int NW = 3 * W + 3;
  localparam int LW = 2 * W + 2;
  localparam int HL = W + 1;
  localparam int QW = W + 2;

  logic [2:0] vld_r;
  logic [3:0] adv;

  logic [W:0]           vmag [3];
  logic [2*W+1:0]       pl_r [3];
  logic [2*W+1:0]       ph_r [3];
  logic [NW-1:0]        num_r [3];
  logic [NW-1:0]        numc_r [3];
  logic [2:0]           neg_r [3];
  logic [2:0]           ovf_r;
  logic                 on_r [3];
  logic                 zl_r [3];
  logic [LW-1:0]        len_r [3];
  logic signed [W-1:0]  sa_r [3];
  logic signed [W-1:0]  sb_r [3];
  logic signed [W-1:0]  sc_r [3];

  assign adv[3] = dn_rdy;
  for (genvar k = 0; k < 3; k++) begin : g_adv
    assign adv[k] = !vld_r[k] || adv[k+1];
  end
  assign up_rdy = adv[0];
  assign dn_vld = vld_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= up_vld;
      for (int k = 1; k < 3; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vmag[i] = dir[i][W] ? -dir[i] : dir[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < 3; i++) begin
        pl_r[i]     <= (2*W+2)'(vmag[i]) * (2*W+2)'(dot_mag[HL-1:0]);
        ph_r[i]     <= (2*W+2)'(vmag[i]) * (2*W+2)'(dot_mag[LW-1:HL]);
        neg_r[0][i] <= dir[i][W] ^ dot_neg;
      end
      on_r[0]  <= on_seg;
      zl_r[0]  <= zero_len;
      len_r[0] <= len;
      sa_r     <= start;
    end
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= (NW'(ph_r[i]) << HL) + NW'(pl_r[i]);
      end
      neg_r[1] <= neg_r[0];
      on_r[1]  <= on_r[0];
      zl_r[1]  <= zl_r[0];
      len_r[1] <= len_r[0];
      sb_r     <= sa_r;
    end
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        // Quotient of 2^QW or more saturates whatever the start point is.
        ovf_r[i] <= (NW+1)'(num_r[i]) >= ((NW+1)'(len_r[1]) << QW);
      end
      numc_r   <= num_r;
      neg_r[2] <= neg_r[1];
      on_r[2]  <= on_r[1];
      zl_r[2]  <= zl_r[1];
      len_r[2] <= len_r[1];
      sc_r     <= sb_r;
    end
  end

  assign on_out    = on_r[2];
  assign zl_out    = zl_r[2];
  assign neg_out   = neg_r[2];
  assign ovf_out   = ovf_r;
  assign num_out   = numc_r;
  assign len_out   = len_r[2];
  assign start_out = sc_r;
endmodule

// File: design/psp_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage, three lanes sharing one
// divisor. Side information rides along in a packed word.
module psp_divider #(
  parameter int W    = psp_pkg::COORD_WIDTH_DEFAULT,
  parameter int SB_W = 3 * psp_pkg::COORD_WIDTH_DEFAULT + 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_vld,
  output logic              up_rdy,
  input  logic [3*W+2:0]    num [3],
  input  logic [2*W+1:0]    len,
  input  logic [SB_W-1:0]   sb_in,
  output logic              dn_vld,
  input  logic              dn_rdy,
  output logic [W+1:0]      quo [3],
  output logic [SB_W-1:0]   sb_out
);
  localparam int NW = 3 * W + 3;
  localparam int LW = 2 * W + 2;
  localparam int QW = W + 2;

  logic [QW-1:0]  vld_r;
  logic [QW:0]    adv;
  logic [NW-1:0]  rem_r [QW][3];
  logic [QW-1:0]  q_r   [QW][3];
  logic [LW-1:0]  len_r [QW];
  logic [SB_W-1:0] sb_r [QW];

  assign adv[QW] = dn_rdy;
  for (genvar k = 0; k < QW; k++) begin : g_adv
    assign adv[k] = !vld_r[k] || adv[k+1];
  end
  assign up_rdy = adv[0];
  assign dn_vld = vld_r[QW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= up_vld;
      for (int k = 1; k < QW; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stg
    localparam int K = QW - 1 - j;
    logic [NW-1:0]   rin [3];
    logic [QW-1:0]   qin [3];
    logic [LW-1:0]   lin;
    logic [SB_W-1:0] sin;
    logic [NW:0]     dsh;
    logic [NW:0]     diff [3];

    if (j == 0) begin : g_first
      assign rin = num;
      assign qin = '{default: '0};
      assign lin = len;
      assign sin = sb_in;
    end else begin : g_next
      assign rin = rem_r[j-1];
      assign qin = q_r[j-1];
      assign lin = len_r[j-1];
      assign sin = sb_r[j-1];
    end

    always_comb begin
      dsh = (NW+1)'(lin) << K;
      for (int i = 0; i < 3; i++) begin
        diff[i] = (NW+1)'(rin[i]) - dsh;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        for (int i = 0; i < 3; i++) begin
          // No borrow means the shifted divisor fits: take the bit.
          if (!diff[i][NW]) begin
            rem_r[j][i] <= diff[i][NW-1:0];
            q_r[j][i]   <= qin[i] | (QW'(1) << K);
          end else begin
            rem_r[j][i] <= rin[i];
            q_r[j][i]   <= qin[i];
          end
        end
        len_r[j] <= lin;
        sb_r[j]  <= sin;
      end
    end
  end

  assign quo    = q_r[QW-1];
  assign sb_out = sb_r[QW-1];
endmodule
